// File: hdl/ppu_video_memory_map_macros.svh
// Assertion macros for the video memory map checker.
// Expects clk and rst_n in the scope of use.
`ifndef PPU_VIDEO_MEMORY_MAP_MACROS_SVH
`define PPU_VIDEO_MEMORY_MAP_MACROS_SVH

// same-cycle implication
`define VMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ppu_vmm_pkg.sv
// Shared types and constants for the video memory map.
// No dependencies.
`timescale 1ns / 1ps

package ppu_vmm_pkg;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int FOLD_W   = 14;   // bus folds modulo 0x4000
  localparam int NT_REL_W = 12;   // 0x2000-0x2FFF span
  localparam int PAT_BYTES = 8192;
  localparam int PAT_AW   = 13;
  localparam int PAL_BYTES = 32;
  localparam int PAL_AW   = 5;
  localparam logic [FOLD_W-9:0] PAL_PAGE = 6'h3F;  // 0x3F00 page

  localparam int TABLE_BYTES_DEF = 1024;
  localparam int PHYS_TABLES_DEF = 4;

  localparam int NUM_SEL = 4;
  localparam int SEL_W   = 2;

  typedef logic [SEL_W-1:0] sel_t;
  typedef logic [DATA_W-1:0] byte_t;

  localparam sel_t SEL_RESET [NUM_SEL] = '{2'd0, 2'd0, 2'd1, 2'd1};

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [SEL_W-1:0] {
    CFG_TABLE0 = 2'd0,
    CFG_TABLE1 = 2'd1,
    CFG_TABLE2 = 2'd2,
    CFG_TABLE3 = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_PATTERN   = 2'd0,
    ST_NAMETABLE = 2'd1,
    ST_PALETTE   = 2'd2
  } store_t;

endpackage

// File: hdl/ppu_vmm_if.sv
// Valid/ready channel interfaces for access beats and read results.
// Depends on ppu_vmm_pkg.
`timescale 1ns / 1ps

interface ppu_vmm_in_if;
  import ppu_vmm_pkg::*;
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [ADDR_W-1:0]   bus_address;
  logic [DATA_W-1:0]   write_byte;

  modport source (output valid, op, bus_address, write_byte, input ready);
  modport sink   (input valid, op, bus_address, write_byte, output ready);
endinterface

interface ppu_vmm_out_if;
  import ppu_vmm_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink   (input valid, read_byte, output ready);
endinterface

// File: hdl/ppu_vmm_decode.sv
// Address fold and decode: picks the store and the entry for one beat.
// Depends on ppu_vmm_pkg.
`timescale 1ns / 1ps

module ppu_vmm_decode #(
  parameter int TABLE_BYTES = ppu_vmm_pkg::TABLE_BYTES_DEF,
  parameter int PHYS_TABLES = ppu_vmm_pkg::PHYS_TABLES_DEF
) (
  input  logic [ppu_vmm_pkg::ADDR_W-1:0]            bus_address,
  input  ppu_vmm_pkg::sel_t                         sel [ppu_vmm_pkg::NUM_SEL],
  output ppu_vmm_pkg::store_t                       kind,
  output logic [ppu_vmm_pkg::PAT_AW-1:0]            pat_addr,
  output logic [$clog2(PHYS_TABLES*TABLE_BYTES)-1:0] nt_addr,
  output logic [ppu_vmm_pkg::PAL_AW-1:0]            pal_addr
);
  import ppu_vmm_pkg::*;

  localparam int NT_AW    = $clog2(PHYS_TABLES*TABLE_BYTES);
  localparam int NT_SPAN  = 1 << NT_REL_W;
  localparam int NUM_MULT = (NT_SPAN + TABLE_BYTES - 1) / TABLE_BYTES - 1;
  localparam int QW       = $clog2(NUM_MULT + 1);

  logic [FOLD_W-1:0]   fold;
  logic [NT_REL_W-1:0] rel;
  logic [NUM_MULT-1:0] ge;
  logic [QW-1:0]       quot;
  logic [ADDR_W-1:0]   offset;
  sel_t                sel_q;
  logic [SEL_W:0]      phys;
  logic [ADDR_W-1:0]   nt_full;
  logic [PAL_AW-1:0]   pal_raw;

  assign fold = bus_address[FOLD_W-1:0];
  assign rel  = fold[NT_REL_W-1:0];  // 0x3000 mirror drops out here

  // thermometer of table boundaries, then count
  always_comb begin
    for (int k = 0; k < NUM_MULT; k++) begin
      ge[k] = {{(ADDR_W-NT_REL_W){1'b0}}, rel} >= ADDR_W'((k + 1) * TABLE_BYTES);
    end
  end

  assign quot   = QW'($countones(ge));
  assign offset = {{(ADDR_W-NT_REL_W){1'b0}}, rel} - ADDR_W'(ADDR_W'(quot) * ADDR_W'(TABLE_BYTES));
  assign sel_q  = sel[quot[1:0]];

  always_comb begin
    if ({1'b0, sel_q} >= (SEL_W+1)'(PHYS_TABLES)) begin
      phys = {1'b0, sel_q} - (SEL_W+1)'(PHYS_TABLES);
    end else begin
      phys = {1'b0, sel_q};
    end
  end

  assign nt_full = ADDR_W'(ADDR_W'(phys) * ADDR_W'(TABLE_BYTES)) + offset;
  assign nt_addr = nt_full[NT_AW-1:0];

  assign pat_addr = fold[PAT_AW-1:0];

  // 0x10/14/18/1C alias the backdrop entries
  assign pal_raw  = fold[PAL_AW-1:0];
  assign pal_addr = (pal_raw[4] && (pal_raw[1:0] == 2'b00)) ? {1'b0, pal_raw[3:0]} : pal_raw;

  always_comb begin
    if (fold[FOLD_W-1:8] == PAL_PAGE) begin
      kind = ST_PALETTE;
    end else if (fold[FOLD_W-1]) begin
      kind = ST_NAMETABLE;
    end else begin
      kind = ST_PATTERN;
    end
  end

endmodule

// File: hdl/ppu_video_memory_map.sv
// Top level of the video memory map: pattern, name-table and palette stores.
// Depends on ppu_vmm_pkg, ppu_vmm_if and ppu_vmm_decode.
`timescale 1ns / 1ps

// Usage
//   in_ch  : one byte access per beat (op, bus_address, write_byte).
//   out_ch : one read_byte beat per read; a write returns nothing.
//   cfg_*  : write port for the four table select registers. The user must write
//            them only while no access is in flight; the block itself leaves this check to the user.
// Read path: a read accepted on in_ch passes through the registered read
//   port of its store and then the output register before it shows on
//   out_ch.
// Throughput: one access per cycle while input ready is high; each store has one write/read port
//   and an access touches exactly one of them at the accept edge.
// Reset: select registers return to 0,0,1,1; palette valid bits clear so
//   the palette reads as zeros; pattern and name-table contents are kept.
//   No clearing pass, the block is ready right after reset.
// Stall: a stalled result sits in the output register while one more read
//   result waits in the read stage; input ready drops only when both are
//   full.
module ppu_video_memory_map #(
  parameter int TABLE_BYTES = ppu_vmm_pkg::TABLE_BYTES_DEF,
  parameter int PHYS_TABLES = ppu_vmm_pkg::PHYS_TABLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  ppu_vmm_pkg::cfg_idx_t          cfg_index,
  input  logic [ppu_vmm_pkg::SEL_W-1:0]  cfg_wdata,
  ppu_vmm_in_if.sink                     in_ch,
  ppu_vmm_out_if.source                  out_ch
);
  import ppu_vmm_pkg::*;

  localparam int NT_BYTES = PHYS_TABLES * TABLE_BYTES;
  localparam int NT_AW    = $clog2(NT_BYTES);

  sel_t                sel_r [NUM_SEL];
  store_t              kind;
  logic [PAT_AW-1:0]   pat_addr;
  logic [NT_AW-1:0]    nt_addr;
  logic [PAL_AW-1:0]   pal_addr;
  logic                acc, acc_rd, acc_wr;

  byte_t               pat_mem [PAT_BYTES];
  byte_t               nt_mem  [NT_BYTES];
  byte_t               pal_mem [PAL_BYTES];
  logic [PAL_BYTES-1:0] pal_vld_r;
  byte_t               pat_rd_r, nt_rd_r, pal_rd_r;
  logic                pal_rd_vld_r;

  logic                s1_valid_r, s1_valid_nxt;
  store_t              s1_kind_r;
  logic                s1_adv;
  byte_t               s1_data;
  logic                out_valid_r, out_valid_nxt;
  byte_t               out_data_r;

  // select registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_RESET;
    end else if (cfg_wr_en) begin
      sel_r[cfg_index] <= cfg_wdata;
    end
  end

  ppu_vmm_decode #(
    .TABLE_BYTES (TABLE_BYTES),
    .PHYS_TABLES (PHYS_TABLES)
  ) u_decode (
    .bus_address (in_ch.bus_address),
    .sel         (sel_r),
    .kind        (kind),
    .pat_addr    (pat_addr),
    .nt_addr     (nt_addr),
    .pal_addr    (pal_addr)
  );

  assign acc    = in_ch.valid && in_ch.ready;
  assign acc_rd = acc && (in_ch.op == OP_READ);
  assign acc_wr = acc && (in_ch.op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (acc_wr && (kind == ST_PATTERN)) begin
      pat_mem[pat_addr] <= in_ch.write_byte;
    end
    if (acc_rd && (kind == ST_PATTERN)) begin
      pat_rd_r <= pat_mem[pat_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_wr && (kind == ST_NAMETABLE)) begin
      nt_mem[nt_addr] <= in_ch.write_byte;
    end
    if (acc_rd && (kind == ST_NAMETABLE)) begin
      nt_rd_r <= nt_mem[nt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_wr && (kind == ST_PALETTE)) begin
      pal_mem[pal_addr] <= in_ch.write_byte;
    end
    if (acc_rd && (kind == ST_PALETTE)) begin
      pal_rd_r     <= pal_mem[pal_addr];
      pal_rd_vld_r <= pal_vld_r[pal_addr];
    end
  end

  // unwritten palette entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (acc_wr && (kind == ST_PALETTE)) begin
      pal_vld_r[pal_addr] <= 1'b1;
    end
  end

  // read stage and output register
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt  = acc_rd || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);
  end

  always_comb begin
    case (s1_kind_r)
      ST_PATTERN:   s1_data = pat_rd_r;
      ST_NAMETABLE: s1_data = nt_rd_r;
      ST_PALETTE:   s1_data = pal_rd_vld_r ? pal_rd_r : '0;
      default:      s1_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_rd) begin
      s1_kind_r <= kind;
    end
    if (s1_adv) begin
      out_data_r <= s1_data;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_byte = out_data_r;

endmodule

// File: hdl/ppu_vmm_checker.sv
// Port-level checks on the video memory map, bound to the top level.
// Depends on ppu_vmm_pkg and ppu_video_memory_map_macros.svh.
`timescale 1ns / 1ps
`include "ppu_video_memory_map_macros.svh"

module ppu_vmm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_op,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ppu_vmm_pkg::DATA_W-1:0] out_read_byte
);
  import ppu_vmm_pkg::*;

  logic in_rd_beat;
  assign in_rd_beat = in_valid && in_ready && (in_op == OP_READ);

  `VMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_byte), "result beat dropped or changed under stall")
  `VMM_ASSERT_NOW(a_reset_empty, !$past(rst_n), !out_valid, "result valid right after reset")
  `VMM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `VMM_ASSERT_NOW(a_result_from_read, $rose(out_valid), $past(in_rd_beat, 2), "result without a read two cycles earlier")

endmodule

bind ppu_video_memory_map ppu_vmm_checker u_vmm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_op         (in_ch.op),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_byte (out_ch.read_byte)
);

// File: test/tb_top.sv
// Self-checking bench for ppu_video_memory_map: byte accesses over the valid/ready channels,
// with read results checked against an in-bench model of the three stores and the table selects.
// Depends on ppu_vmm_pkg, ppu_vmm_if and the ppu_video_memory_map RTL.
`timescale 1ns / 1ps

module tb_top;
  import ppu_vmm_pkg::*;

  localparam int TBL = TABLE_BYTES_DEF;
  localparam int PHYS = PHYS_TABLES_DEF;
  localparam int NT_BYTES = TBL * PHYS;
  localparam int NT_BASE = 'h2000;
  localparam int NT_END = 'h3000;
  localparam int PAL_BASE = 'h3F00;
  localparam int GAP_MAX = 14;
  localparam int SETTLE = 8;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 117;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    byte_t value;
  } read_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  cfg_idx_t cfg_index;
  logic [SEL_W-1:0] cfg_wdata;

  ppu_vmm_in_if acc_if ();
  ppu_vmm_out_if rd_if ();

  ppu_video_memory_map #(
    .TABLE_BYTES(TBL),
    .PHYS_TABLES(PHYS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(acc_if),
    .out_ch(rd_if)
  );

  byte_t pat_mem [PAT_BYTES];
  bit pat_known [PAT_BYTES];
  int pat_list [$];
  byte_t nt_mem [NT_BYTES];
  bit nt_known [NT_BYTES];
  int nt_list [$];
  byte_t pal_mem [PAL_BYTES];
  sel_t table_sel [NUM_SEL];
  read_beat_t pending_reads [$];
  read_beat_t got_beat;

  int fail_count = 0;
  int cycle_count = 0;
  int tx_gap_max = GAP_MAX;
  int rx_gap_max = GAP_MAX;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // fold, mirror and alias a bus address down to one backing byte
  function automatic void locate_byte(input logic [ADDR_W-1:0] addr, output store_t kind,
                                      output int idx);
    int folded;
    int rel;
    int logical;
    folded = int'(addr[FOLD_W-1:0]);
    if (folded >= PAL_BASE) begin
      idx = folded % PAL_BYTES;
      if ((idx & 'h13) == 'h10) idx = idx & 'h0F;
      kind = ST_PALETTE;
    end else begin
      if (folded >= NT_END) folded = folded - NT_END + NT_BASE;
      if (folded >= NT_BASE) begin
        rel = folded - NT_BASE;
        logical = (rel / TBL) % NUM_SEL;
        idx = (int'(table_sel[logical]) % PHYS) * TBL + rel % TBL;
        kind = ST_NAMETABLE;
      end else begin
        idx = folded % PAT_BYTES;
        kind = ST_PATTERN;
      end
    end
  endfunction

  task automatic apply_access(input op_t op, input logic [ADDR_W-1:0] addr, input byte_t data);
    store_t kind;
    int idx;
    read_beat_t beat;
    locate_byte(addr, kind, idx);
    if (op == OP_WRITE) begin
      case (kind)
        ST_PATTERN: begin
          if (!pat_known[idx]) pat_list.push_back(idx);
          pat_known[idx] = 1'b1;
          pat_mem[idx] = data;
        end
        ST_NAMETABLE: begin
          if (!nt_known[idx]) nt_list.push_back(idx);
          nt_known[idx] = 1'b1;
          nt_mem[idx] = data;
        end
        default: pal_mem[idx] = data;
      endcase
    end else begin
      beat.addr = addr;
      case (kind)
        ST_PATTERN: beat.value = pat_mem[idx];
        ST_NAMETABLE: beat.value = nt_mem[idx];
        default: beat.value = pal_mem[idx];
      endcase
      pending_reads.push_back(beat);
    end
  endtask

  // bus address of an already written byte; falls back to a palette address
  function automatic bit pick_known_addr(input store_t kind, output logic [ADDR_W-1:0] addr);
    logic [1:0] hi;
    int idx;
    int rel;
    int l;
    int hits [$];
    hi = 2'($urandom_range(0, 3));
    addr = {hi, PAL_PAGE, 8'($urandom_range(0, 255))};
    case (kind)
      ST_PATTERN: begin
        if (pat_list.size() == 0) return 1'b0;
        idx = pat_list[$urandom_range(0, pat_list.size() - 1)];
        addr = {hi, 1'b0, 13'(idx)};
      end
      ST_NAMETABLE: begin
        if (nt_list.size() == 0) return 1'b0;
        idx = nt_list[$urandom_range(0, nt_list.size() - 1)];
        for (l = 0; l < NUM_SEL; l++) begin
          if (int'(table_sel[l]) % PHYS == idx / TBL) hits.push_back(l);
        end
        if (hits.size() == 0) return 1'b0;
        rel = hits[$urandom_range(0, hits.size() - 1)] * TBL + idx % TBL;
        if ($urandom_range(0, 1) == 1 && rel < PAL_BASE - NT_END) begin
          addr = {hi, 14'(NT_END + rel)};
        end else begin
          addr = {hi, 14'(NT_BASE + rel)};
        end
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] random_write_addr();
    logic [1:0] hi;
    int rel;
    hi = 2'($urandom_range(0, 3));
    rel = $urandom_range(0, NT_END - NT_BASE - 1);
    case ($urandom_range(0, 9))
      0, 1: begin
        return 16'($urandom_range(0, 65535));
      end
      2, 3, 4: begin
        return {hi, 1'b0, 13'($urandom_range(0, PAT_BYTES - 1))};
      end
      5, 6, 7: begin
        if (rel < PAL_BASE - NT_END && $urandom_range(0, 1) == 1) return {hi, 14'(NT_END + rel)};
        return {hi, 14'(NT_BASE + rel)};
      end
      default: begin
        return {hi, PAL_PAGE, 8'($urandom_range(0, 255))};
      end
    endcase
  endfunction

  function automatic sel_t phase_select(input int phase, input int t);
    case (phase)
      0: return SEL_RESET[t];
      1: return sel_t'(0);
      2: return sel_t'(3);
      3: return sel_t'(t);
      4: return sel_t'(3 - t);
      default: return sel_t'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_access(input op_t op, input logic [ADDR_W-1:0] addr, input byte_t data);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      acc_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    acc_if.op = op;
    acc_if.bus_address = addr;
    acc_if.write_byte = data;
    acc_if.valid = 1'b1;
    do @(posedge clk); while (!acc_if.ready);
    apply_access(op, addr, data);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    acc_if.valid = 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_select(input cfg_idx_t idx, input sel_t value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    table_sel[idx] = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic test_palette_reset();
    send_access(OP_READ, 16'h3F00, 8'h00);
    send_access(OP_READ, 16'hFF1F, 8'hFF);
  endtask

  task automatic test_pattern_range();
    send_access(OP_WRITE, 16'h0000, 8'hA5);
    send_access(OP_WRITE, 16'h1FFF, 8'hFF);
    send_access(OP_READ, 16'hC000, 8'h00);
    send_access(OP_READ, 16'h5FFF, 8'h00);
    send_access(OP_WRITE, 16'h1000, 8'h00);
    send_access(OP_READ, 16'h9000, 8'hFF);
  endtask

  // reset selects: logical 0/1 share one physical table, 2/3 another
  task automatic test_nametable_map();
    send_access(OP_WRITE, 16'h2000, 8'h3C);
    send_access(OP_READ, 16'h2400, 8'h00);
    send_access(OP_READ, 16'h3000, 8'h00);
    send_access(OP_WRITE, 16'h2FFF, 8'hC3);
    send_access(OP_READ, 16'h2BFF, 8'h00);
    send_access(OP_WRITE, 16'h3EFF, 8'h81);
    send_access(OP_READ, 16'hEAFF, 8'h00);
  endtask

  task automatic test_palette_alias();
    send_access(OP_WRITE, 16'h3F10, 8'hFF);
    send_access(OP_READ, 16'h3F00, 8'h00);
    send_access(OP_WRITE, 16'h3F04, 8'h7E);
    send_access(OP_READ, 16'h3F14, 8'h00);
    send_access(OP_WRITE, 16'h3F18, 8'h81);
    send_access(OP_READ, 16'h7F08, 8'h00);
    send_access(OP_WRITE, 16'h3F0C, 8'h55);
    send_access(OP_READ, 16'hBF3C, 8'h00);
    send_access(OP_READ, 16'h3FFF, 8'hFF);
  endtask

  task automatic test_random_traffic();
    int phase;
    int sent;
    int t;
    int pick;
    byte_t data;
    logic [ADDR_W-1:0] addr;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      for (t = 0; t < NUM_SEL; t++) write_select(cfg_idx_t'(t), phase_select(phase, t));
      tx_gap_max = (phase == 1 || phase == 4) ? 0 : GAP_MAX;
      rx_gap_max = (phase == 1 || phase == 3) ? 0 : GAP_MAX;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        if (pick < 35) begin
          send_access(OP_WRITE, random_write_addr(), data);
          sent++;
        end else if (pick < 50) begin
          if (!pick_known_addr(store_t'($urandom_range(0, 2)), addr)) addr = random_write_addr();
          send_access(OP_WRITE, addr, data);
          sent++;
        end else if (pick < 85) begin
          void'(pick_known_addr(store_t'($urandom_range(0, 2)), addr));
          send_access(OP_READ, addr, data);
          sent++;
        end else begin
          // write then read back through another fold of the same address
          addr = random_write_addr();
          send_access(OP_WRITE, addr, data);
          send_access(OP_READ, addr ^ {2'($urandom_range(1, 3)), 14'h0000}, ~data);
          sent += 2;
        end
      end
    end
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
  endtask

  initial begin
    int stall;
    rd_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (stall != 0) begin
        rd_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rd_if.ready = 1'b1;
      do @(posedge clk); while (!(rd_if.valid && rd_if.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rd_if.valid && rd_if.ready) begin
      if (pending_reads.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("unexpected read beat: %02h", rd_if.read_byte);
      end else begin
        got_beat = pending_reads.pop_front();
        if (rd_if.read_byte !== got_beat.value) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("read of %04h: got %02h, want %02h", got_beat.addr, rd_if.read_byte,
                     got_beat.value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_TABLE0;
    cfg_wdata = '0;
    acc_if.valid = 1'b0;
    acc_if.op = OP_READ;
    acc_if.bus_address = '0;
    acc_if.write_byte = '0;
    for (i = 0; i < PAL_BYTES; i++) pal_mem[i] = '0;
    for (i = 0; i < NUM_SEL; i++) table_sel[i] = SEL_RESET[i];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_palette_reset();
    test_pattern_range();
    test_nametable_map();
    test_palette_alias();
    test_random_traffic();
    wait_for_results();

    if (fail_count == 0 && pending_reads.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ppu_vmm_pkg.sv
hdl/ppu_vmm_if.sv
hdl/ppu_vmm_decode.sv
hdl/ppu_video_memory_map.sv
hdl/ppu_vmm_checker.sv
test/tb_top.sv
